// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL; all checks run on i_clk, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define SCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define SCS_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/scs_pkg.sv =====
`default_nettype none

package scs_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [1:0] CFG_PATTERN_HIGH   = 2'd2;

    localparam int          CFG_DATA_W  = 64;
    localparam int          CFG_LEN_W   = 5;
    localparam int          PAT_BYTES   = 16;
    localparam logic [7:0]  STAR_CHAR   = 8'd42;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    // One result beat as held in the output register
    typedef struct packed {
        logic [15:0] match_count;
        logic        line_done;
        logic        file_done;
        logic        was_censored;
        logic        out_char_valid;
        logic [7:0]  out_byte;
    } t_beat;

endpackage

`default_nettype wire

// ===== hdl/substring_censor_stream.sv =====
`default_nettype none

// Channel   | Dir | Contents
// s_axis    | in  | tdata[7:0] text_byte; tuser[0] char_present, tuser[1] file_end;
//           |     | tlast line_end
// m_axis    | out | tdata[7:0] out_byte, tdata[23:8] match_count;
//           |     | tuser[0] out_char_valid, tuser[1] was_censored, tuser[2] file_done;
//           |     | tlast line_done
// cfg       | in  | i_cfg_we, i_cfg_index, i_cfg_wdata[63:0]; write-only
//
// A character beat passes the input register, one parallel window compare and the
// output register; the next beat enters as the held one is pushed. A line end flushes
// each held byte, then emits the marker beat; after the pattern length is cut mid-line,
// the surplus held bytes drain first, one per cycle while the output is free. Each cycle
// emits at most one result beat. Reset is synchronous, active low; it clears control
// state and the match count. Output stalls hold both registers; a held beat keeps s_axis_tready low.
module substring_censor_stream
    import scs_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // slave stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] text_byte
    input  wire logic [1:0]            s_axis_tuser,   // [0] char_present, [1] file_end
    input  wire logic                  s_axis_tlast,   // line_end
    // master stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [23:0]                m_axis_tdata,   // [7:0] out_byte, [23:8] match_count
    output logic [2:0]                 m_axis_tuser,   // [0] char_valid, [1] censored, [2] file_done
    output logic                       m_axis_tlast,   // line_done
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int FW = $clog2(MAX_PATTERN + 1);

    typedef logic [MAX_PATTERN-1:0][7:0] t_win;
    typedef logic [MAX_PATTERN-1:0]      t_mark;

    // configuration
    logic [CFG_LEN_W-1:0]  r_cfg_len;
    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [PAT_BYTES-1:0][7:0] pat;

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_char, r_in_lend, r_in_fend;
    logic       r_pushed, n_pushed;

    // window state
    t_win          r_win, n_win, cand;
    t_mark         r_mark, n_mark, cand_mark;
    logic [FW-1:0] r_fill, n_fill, fill_inc;
    logic [FW-1:0] r_guard, n_guard, guard_dec;
    logic [15:0]   r_count, n_count;

    // output register
    logic  r_out_valid, n_out_valid;
    t_beat r_out, n_out;

    logic          out_free, step_done, emit_mark;
    logic [FW-1:0] eff_len;
    logic          full, eq, hit;

    assign pat      = {r_pat_hi, r_pat_lo};
    assign out_free = !r_out_valid || m_axis_tready;

    // pattern length clamped to 1..MAX_PATTERN
    always_comb begin
        if (r_cfg_len == '0) begin
            eff_len = FW'(1);
        end else if (r_cfg_len > CFG_LEN_W'(MAX_PATTERN)) begin
            eff_len = FW'(MAX_PATTERN);
        end else begin
            eff_len = FW'(r_cfg_len);
        end
    end

    // window with the new byte written at the fill point, and the compare on it
    always_comb begin
        fill_inc  = r_fill + FW'(1);
        guard_dec = (r_guard != '0) ? r_guard - FW'(1) : '0;
        full      = (fill_inc == eff_len);
        eq        = 1'b1;
        cand      = r_win;
        cand_mark = r_mark;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (FW'(i) == r_fill) begin
                cand[i]      = r_in_byte;
                cand_mark[i] = 1'b0;
            end
        end
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (FW'(i) < eff_len && cand[i] != pat[i]) begin
                eq = 1'b0;
            end
        end
        hit = full && (guard_dec == '0) && eq;
        if (hit) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (FW'(i) < eff_len) begin
                    cand_mark[i] = 1'b1;
                end
            end
        end
    end

    // one step of the held beat: drain, push, flush or marker
    always_comb begin
        n_win       = r_win;
        n_mark      = r_mark;
        n_fill      = r_fill;
        n_guard     = r_guard;
        n_count     = r_count;
        n_pushed    = r_pushed;
        n_out       = r_out;
        n_out_valid = r_out_valid && !m_axis_tready;
        step_done   = 1'b0;
        emit_mark   = 1'b0;

        if (r_in_valid && out_free) begin
            if (r_in_char && !r_pushed && r_fill >= eff_len) begin
                // surplus after a length cut: emit oldest
                n_out_valid = 1'b1;
                n_out = '{match_count: r_count, line_done: 1'b0, file_done: 1'b0,
                          was_censored: r_mark[0], out_char_valid: 1'b1,
                          out_byte: r_mark[0] ? STAR_CHAR : r_win[0]};
                n_win  = r_win >> 8;
                n_mark = r_mark >> 1;
                n_fill = r_fill - FW'(1);
            end else if (r_in_char && !r_pushed) begin
                // push and compare
                n_pushed  = 1'b1;
                step_done = !(r_in_lend || r_in_fend);
                if (hit) begin
                    n_guard = eff_len;
                    n_count = (r_count != COUNT_MAX) ? r_count + 16'd1 : r_count;
                end else begin
                    n_guard = guard_dec;
                end
                if (full) begin
                    n_out_valid = 1'b1;
                    n_out = '{match_count: n_count, line_done: 1'b0, file_done: 1'b0,
                              was_censored: cand_mark[0], out_char_valid: 1'b1,
                              out_byte: cand_mark[0] ? STAR_CHAR : cand[0]};
                    n_win  = cand >> 8;
                    n_mark = cand_mark >> 1;
                    n_fill = r_fill;
                end else begin
                    n_win  = cand;
                    n_mark = cand_mark;
                    n_fill = fill_inc;
                end
            end else if (r_in_lend || r_in_fend) begin
                if (r_fill != '0) begin
                    // line-end flush
                    n_out_valid = 1'b1;
                    n_out = '{match_count: r_count, line_done: 1'b0, file_done: 1'b0,
                              was_censored: r_mark[0], out_char_valid: 1'b1,
                              out_byte: r_mark[0] ? STAR_CHAR : r_win[0]};
                    n_win  = r_win >> 8;
                    n_mark = r_mark >> 1;
                    n_fill = r_fill - FW'(1);
                end else begin
                    // marker beat closes the line
                    emit_mark   = 1'b1;
                    n_out_valid = 1'b1;
                    n_out = '{match_count: r_count, line_done: 1'b1, file_done: r_in_fend,
                              was_censored: 1'b0, out_char_valid: 1'b0, out_byte: 8'd0};
                    n_guard   = '0;
                    n_count   = r_in_fend ? 16'd0 : r_count;
                    step_done = 1'b1;
                end
            end else begin
                // empty beat
                step_done = 1'b1;
            end
        end

        if (s_axis_tvalid && (!r_in_valid || step_done)) begin
            n_in_valid = 1'b1;
            n_pushed   = 1'b0;
        end else if (step_done) begin
            n_in_valid = 1'b0;
            n_pushed   = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    assign s_axis_tready = !r_in_valid || step_done;

    // state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len   <= CFG_LEN_W'(1);
            r_pat_lo    <= '0;
            r_pat_hi    <= '0;
            r_in_valid  <= 1'b0;
            r_pushed    <= 1'b0;
            r_fill      <= '0;
            r_guard     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PATTERN_LENGTH: r_cfg_len <= i_cfg_wdata[CFG_LEN_W-1:0];
                    CFG_PATTERN_LOW:    r_pat_lo  <= i_cfg_wdata;
                    CFG_PATTERN_HIGH:   r_pat_hi  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_in_valid  <= n_in_valid;
            r_pushed    <= n_pushed;
            r_fill      <= n_fill;
            r_guard     <= n_guard;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_char <= s_axis_tuser[0];
            r_in_fend <= s_axis_tuser[1];
            r_in_lend <= s_axis_tlast;
        end
        r_win  <= n_win;
        r_mark <= n_mark;
        r_out  <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.match_count, r_out.out_byte};
    assign m_axis_tuser  = {r_out.file_done, r_out.was_censored, r_out.out_char_valid};
    assign m_axis_tlast  = r_out.line_done;

    // checks
    `include "assert_macros.svh"

    `SCS_ASSERT(a_fill_bound, r_fill <= FW'(MAX_PATTERN), "window fill beyond depth")
    `SCS_ASSERT(a_guard_bound, r_guard <= FW'(MAX_PATTERN), "overlap guard beyond depth")
    `SCS_ASSERT(a_accept_holds, (s_axis_tvalid && s_axis_tready) |=> r_in_valid,
                "accepted beat not held")
    `SCS_ASSERT(a_marker_empties, emit_mark |=> (r_fill == '0 && r_guard == '0),
                "marker left window or guard set")

endmodule

`default_nettype wire

// ===== dv/substring_censor_stream_test.sv =====
`default_nettype none

module substring_censor_stream_test
    import scs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_SETTLE = 40;   // covers a full window flush plus marker

    // One text beat as offered on the slave stream
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       line_end;
        logic       file_end;
    } t_text_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;    // [7:0] text_byte
    logic [1:0]            s_axis_tuser = '0;    // [0] char_present, [1] file_end
    logic                  s_axis_tlast = 1'b0;  // line_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;         // [7:0] out_byte, [23:8] match_count
    logic [2:0]            m_axis_tuser;         // [0] char_valid, [1] censored, [2] file_done
    logic                  m_axis_tlast;         // line_done
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_index = CFG_PATTERN_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    substring_censor_stream u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Mirror of the censor state and its registers
    logic [CFG_LEN_W-1:0]  cfg_len = 5'd1;
    logic [CFG_DATA_W-1:0] cfg_pat_lo = '0;
    logic [CFG_DATA_W-1:0] cfg_pat_hi = '0;
    logic [7:0]            win_bytes [PAT_BYTES];
    bit                    win_marks [PAT_BYTES];
    int                    win_fill = 0;
    int                    guard_left = 0;
    logic [15:0]           file_count = '0;

    t_beat masked_text_q[$];

    int mismatch_count = 0;
    int beats_checked = 0;
    int censored_seen = 0;
    int text_beats_in = 0;
    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int rcv_hold_left = 0;

    initial begin
        foreach (win_bytes[i]) begin
            win_bytes[i] = '0;
            win_marks[i] = 1'b0;
        end
    end

    function automatic int active_len();
        int n;
        n = cfg_len;
        if (n < 1) n = 1;
        if (n > PAT_BYTES) n = PAT_BYTES;
        return n;
    endfunction

    function automatic logic [7:0] pattern_byte(input int i);
        if (i < 8) return cfg_pat_lo[8*i +: 8];
        return cfg_pat_hi[8*(i-8) +: 8];
    endfunction

    // Release the oldest held byte, starred if it was part of a match
    function automatic void release_oldest();
        t_beat b;
        if (win_fill == 0) return;
        b = '0;
        b.out_char_valid = 1'b1;
        b.was_censored   = win_marks[0];
        b.out_byte       = win_marks[0] ? STAR_CHAR : win_bytes[0];
        b.match_count    = file_count;
        masked_text_q.push_back(b);
        for (int i = 0; i < PAT_BYTES - 1; i++) begin
            win_bytes[i] = win_bytes[i+1];
            win_marks[i] = win_marks[i+1];
        end
        win_bytes[PAT_BYTES-1] = '0;
        win_marks[PAT_BYTES-1] = 1'b0;
        win_fill--;
    endfunction

    // Predict the beats one accepted text beat produces
    function automatic void mask_text_beat(input t_text_item it);
        int   len;
        bit   hit;
        t_beat b;
        len = active_len();
        if (it.has_char) begin
            if (win_fill >= PAT_BYTES) release_oldest();
            win_bytes[win_fill] = it.ch;
            win_marks[win_fill] = 1'b0;
            win_fill++;
            // a shortened pattern lets surplus held bytes out first
            while (win_fill > len) release_oldest();
            if (guard_left > 0) guard_left--;
            if (win_fill == len && guard_left == 0) begin
                hit = 1'b1;
                for (int i = 0; i < len; i++)
                    if (win_bytes[i] != pattern_byte(i)) hit = 1'b0;
                if (hit) begin
                    for (int i = 0; i < len; i++) win_marks[i] = 1'b1;
                    guard_left = len;
                    if (file_count != COUNT_MAX) file_count++;
                end
            end
            if (win_fill == len) release_oldest();
        end
        // line or file end: flush, then the marker beat
        if (it.line_end || it.file_end) begin
            while (win_fill > 0) release_oldest();
            guard_left = 0;
            b = '0;
            b.line_done   = 1'b1;
            b.file_done   = it.file_end;
            b.match_count = file_count;
            masked_text_q.push_back(b);
            if (it.file_end) file_count = '0;
        end
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_checked++;
            if (masked_text_q.size() == 0) begin
                $error("result beat with nothing pending: tdata %0h tuser %0b tlast %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = masked_text_q.pop_front();
                if (want.was_censored) censored_seen++;
                compare_field("out_byte", want.out_byte, m_axis_tdata[7:0]);
                compare_field("match_count", want.match_count, m_axis_tdata[23:8]);
                compare_field("out_char_valid", want.out_char_valid, m_axis_tuser[0]);
                compare_field("was_censored", want.was_censored, m_axis_tuser[1]);
                compare_field("file_done", want.file_done, m_axis_tuser[2]);
                compare_field("line_done", want.line_done, m_axis_tlast);
            end
        end
    end

    // Receiver: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (rcv_hold_left > 0) begin
            rcv_hold_left--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Offer one beat; entered and left at a falling edge
    task automatic offer_text_beat(input t_text_item it);
        int gap;
        gap = 0;
        while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = it.ch;
        s_axis_tuser  = {it.file_end, it.has_char};
        s_axis_tlast  = it.line_end;
        do @(posedge i_clk); while (!s_axis_tready);
        mask_text_beat(it);
        text_beats_in++;
        @(negedge i_clk);
    endtask

    task automatic offer_char(input logic [7:0] ch, input logic lend, input logic fend);
        t_text_item it;
        it = '{ch: ch, has_char: 1'b1, line_end: lend, file_end: fend};
        offer_text_beat(it);
    endtask

    // Stop offering, let every pending beat out, then let the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (masked_text_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_PATTERN_LENGTH: cfg_len = val[CFG_LEN_W-1:0];
            CFG_PATTERN_LOW:    cfg_pat_lo = val;
            CFG_PATTERN_HIGH:   cfg_pat_hi = val;
            default: ;
        endcase
    endtask

    task automatic load_pattern(input logic [CFG_LEN_W-1:0] len, input logic [127:0] bytes);
        write_reg(CFG_PATTERN_LENGTH, {{(CFG_DATA_W-CFG_LEN_W){1'b0}}, len});
        write_reg(CFG_PATTERN_LOW, bytes[63:0]);
        write_reg(CFG_PATTERN_HIGH, bytes[127:64]);
    endtask

    // Mostly a small alphabet so matches happen often
    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 45) return "a";
        if (r < 80) return "b";
        if (r < 88) return "c";
        return 8'($urandom_range(255));
    endfunction

    task automatic test_directed_cases();
        t_text_item it;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        // overlapping occurrences: only the leftmost counts
        load_pattern(5'd3, 128'h616261);
        offer_char("a", 1'b0, 1'b0);
        offer_char("b", 1'b0, 1'b0);
        offer_char("a", 1'b0, 1'b0);
        offer_char("b", 1'b0, 1'b0);
        offer_char("a", 1'b0, 1'b0);
        // marker-only line end flushes the window
        it = '{ch: 8'h00, has_char: 1'b0, line_end: 1'b1, file_end: 1'b0};
        offer_text_beat(it);
        // empty beat gives nothing
        it = '{ch: 8'hFF, has_char: 1'b0, line_end: 1'b0, file_end: 1'b0};
        offer_text_beat(it);
        wait_idle();
        // length zero acts as one; file end without line end
        load_pattern(5'd0, 128'hFF);
        offer_char(8'hFF, 1'b0, 1'b0);
        offer_char(8'h00, 1'b0, 1'b1);
        wait_idle();
        // oversized length acts as the maximum, then cut mid-line
        load_pattern(5'd31, {128{1'b1}});
        offer_char("q", 1'b0, 1'b0);
        offer_char("r", 1'b0, 1'b0);
        offer_char("s", 1'b0, 1'b0);
        wait_idle();
        load_pattern(5'd2, 128'h7473);
        offer_char("t", 1'b0, 1'b0);
        offer_char("u", 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_text(input int n_items, input int snd_pct, input int rcv_pct,
                                    input logic [CFG_LEN_W-1:0] len);
        logic [127:0] pat;
        t_text_item   it;
        int           sent;
        int           r;
        pat = '0;
        for (int i = 0; i < PAT_BYTES; i++) pat[8*i +: 8] = pick_text_byte();
        wait_idle();
        load_pattern(len, pat);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 25) begin
                // plant a whole occurrence of the pattern
                for (int i = 0; i < active_len(); i++) offer_char(pattern_byte(i), 1'b0, 1'b0);
                sent += active_len();
            end else if (r < 28) begin
                it = '{ch: 8'($urandom_range(255)), has_char: 1'b0,
                       line_end: 1'b0, file_end: 1'b0};
                offer_text_beat(it);
            end else if (r < 33) begin
                it = '{ch: 8'($urandom_range(255)), has_char: 1'b0, line_end: 1'b1,
                       file_end: ($urandom_range(3) == 0)};
                offer_text_beat(it);
                sent++;
            end else begin
                offer_char(pick_text_byte(), ($urandom_range(99) < 8),
                           ($urandom_range(99) < 2));
                sent++;
            end
        end
        wait_idle();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        logic [127:0] pat;
        pat = '0;
        for (int i = 0; i < 4; i++) pat[8*i +: 8] = pick_text_byte();
        load_pattern(5'd4, pat);
        // receiver holds off while the sender keeps offering
        rcv_hold_left = 300;
        for (int i = 0; i < 40; i++) offer_char(pick_text_byte(), 1'b0, 1'b0);
        // sender pauses until every pending beat is out
        s_axis_tvalid = 1'b0;
        while (masked_text_q.size() != 0) @(negedge i_clk);
        for (int i = 0; i < 4; i++) offer_char(pattern_byte(i), 1'b0, 1'b0);
        offer_char(pick_text_byte(), 1'b1, 1'b0);
        wait_idle();
    endtask

    initial begin
        int waited;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_text(44, 0, 0, 5'd3);
        test_random_text(44, 72, 0, 5'd16);
        test_random_text(44, 0, 72, 5'd0);
        test_random_text(44, 9, 9, 5'd31);
        test_random_text(44, 0, 0, 5'($urandom_range(6, 1)));
        test_backpressure();

        s_axis_tvalid = 1'b0;
        waited = 0;
        while (masked_text_q.size() != 0 && waited < 2000) begin
            @(negedge i_clk);
            waited++;
        end
        if (masked_text_q.size() != 0) begin
            $error("%0d result beats never arrived", masked_text_q.size());
            mismatch_count++;
        end
        repeat (DRAIN_SETTLE) @(negedge i_clk);

        $display("run covered %0d text beats in and %0d result beats checked, %0d starred;",
                 text_beats_in, beats_checked, censored_seen);
        $display("pattern lengths 0 to 31, idle and stall mixes, long hold-off, length cuts");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/scs_pkg.sv
hdl/substring_censor_stream.sv
dv/substring_censor_stream_test.sv
